// ===== design/dspm_pkg.sv =====
`timescale 1ns / 1ps

package dspm_pkg;

   localparam logic [7:0] STAR_BYTE = 8'h2A;
   localparam logic [7:0] DOT_BYTE  = 8'h2E;
   localparam logic [7:0] NUL_BYTE  = 8'h00;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_TEXT   = 2'd2,
      ACT_FINISH = 2'd3
   } action_type;

   // One-hot strobes for the word that leaves the input register this cycle.
   typedef struct packed {
      logic clear;
      logic append;
      logic text;
      logic finish;
   } cmd_type;

endpackage

// ===== design/dspm_token_store.sv =====
`timescale 1ns / 1ps

module dspm_token_store #(
   parameter int N  = 32,
   parameter int CW = 6
) (
   input  logic            clock,
   input  logic            reset,
   input  dspm_pkg::cmd_type cmd,
   input  logic [7:0]      symbol,
   output logic [N-1:0]    hit_vec,
   output logic [N-1:0]    star_vec,
   output logic [CW-1:0]   token_count,
   output logic            overflow
);
   import dspm_pkg::*;

   localparam int IW = (N > 1) ? $clog2(N) : 1;

   logic [7:0]    tok_byte_ff [N];
   logic [N-1:0]  tok_star_ff;
   logic [N-1:0]  tok_wild_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          overflow_ff;
   logic          overflow_in;
   logic [N-1:0]  valid_vec;
   logic [IW-1:0] last_idx;
   logic [IW-1:0] next_idx;
   logic          star_last;
   logic          store_full;
   logic          do_star;
   logic          do_write;

   assign last_idx   = IW'(count_ff - CW'(1));
   assign next_idx   = IW'(count_ff);
   assign store_full = (count_ff == CW'(N));

   // A star only marks the last token when that token is there and not yet starred.
   assign star_last = (count_ff != '0) && !tok_star_ff[last_idx];
   assign do_star   = cmd.append && !overflow_ff && (symbol == STAR_BYTE) && star_last;
   assign do_write  = cmd.append && !overflow_ff && !do_star && !store_full;

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (cmd.clear) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (cmd.append && !overflow_ff && !do_star) begin
         if (store_full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_star) begin
         tok_star_ff[last_idx] <= 1'b1;
      end
      if (do_write) begin
         tok_byte_ff[next_idx] <= symbol;
         tok_star_ff[next_idx] <= 1'b0;
         tok_wild_ff[next_idx] <= (symbol == DOT_BYTE);
      end
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         valid_vec[i] = (CW'(i) < count_ff);
         hit_vec[i]   = valid_vec[i] && (symbol != NUL_BYTE) &&
                        (tok_wild_ff[i] || (tok_byte_ff[i] == symbol));
      end
   end

   assign star_vec    = tok_star_ff & valid_vec;
   assign token_count = count_ff;
   assign overflow    = overflow_ff;

endmodule

// ===== design/dspm_active_set.sv =====
`timescale 1ns / 1ps

module dspm_active_set #(
   parameter int N  = 32,
   parameter int CW = 6
) (
   input  logic            clock,
   input  logic            reset,
   input  dspm_pkg::cmd_type cmd,
   input  logic [N-1:0]    hit_vec,
   input  logic [N-1:0]    star_vec,
   input  logic [CW-1:0]   token_count,
   output logic            end_active
);
   import dspm_pkg::*;

   logic [N:0] active_ff;
   logic [N:0] active_in;
   logic [N:0] star_ext;
   logic [N:0] seed;
   logic [N:0] sum;
   logic [N:0] carries;
   logic [N:0] closed;
   logic [N-1:0] take;

   // Closure over starred tokens is a carry chain: a starred token propagates,
   // and an active starred token generates. The adder resolves it in one pass.
   assign star_ext = {1'b0, star_vec};
   assign seed     = active_ff & star_ext;
   assign sum      = star_ext + seed;
   assign carries  = sum ^ star_ext ^ seed;
   assign closed   = active_ff | carries;

   assign take       = closed[N-1:0] & hit_vec;
   assign end_active = closed[token_count];

   always_comb begin
      active_in = active_ff;
      if (cmd.clear || cmd.append || cmd.finish) begin
         active_in = (N+1)'(1);
      end else if (cmd.text) begin
         active_in = {1'b0, take & star_vec} | {take & ~star_vec, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= (N+1)'(1);
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

// ===== design/dot_star_pattern_matcher_core.sv =====
`timescale 1ns / 1ps
// Channel  Ports                                   Direction  Moves
// req      req_valid/ready, req_action, req_symbol  in         one pattern, text or control word
// rsp      rsp_valid/ready, rsp_matched,             out        one verdict per end-of-text word
//          rsp_pattern_overflow
//
// One word per cycle is sustained while no verdict is blocked; a word passes through the
// input register, and its state update or verdict is done by the logic behind it.
// An end-of-text verdict is registered on rsp as its word leaves the input register.
// Reset (synchronous) empties the pattern, clears overflow and arms position zero.
// The input register holds only while a verdict waits in it and rsp is stalled;
// pattern and text words still flow past a stalled verdict.

module dot_star_pattern_matcher_core #(
   parameter int PATTERN_TOKENS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [7:0] req_symbol,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic       rsp_pattern_overflow
);
   import dspm_pkg::*;

   localparam int CW = $clog2(PATTERN_TOKENS + 1);

   logic          in_valid_ff;
   action_type    in_action_ff;
   logic [7:0]    in_symbol_ff;
   logic          advance;
   cmd_type       cmd;
   logic [PATTERN_TOKENS-1:0] hit_vec;
   logic [PATTERN_TOKENS-1:0] star_vec;
   logic [CW-1:0] token_count;
   logic          overflow;
   logic          end_active;
   logic          rsp_valid_ff;
   logic          rsp_matched_ff;
   logic          rsp_overflow_ff;

   assign advance   = in_valid_ff &&
                      ((in_action_ff != ACT_FINISH) || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      cmd = '0;
      if (advance) begin
         unique case (in_action_ff)
            ACT_CLEAR:  cmd.clear  = 1'b1;
            ACT_APPEND: cmd.append = 1'b1;
            ACT_TEXT:   cmd.text   = 1'b1;
            ACT_FINISH: cmd.finish = 1'b1;
            default:    cmd        = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= action_type'(req_action);
         in_symbol_ff <= req_symbol;
      end
   end

   dspm_token_store #(
      .N  (PATTERN_TOKENS),
      .CW (CW)
   ) u_token_store (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .symbol      (in_symbol_ff),
      .hit_vec     (hit_vec),
      .star_vec    (star_vec),
      .token_count (token_count),
      .overflow    (overflow)
   );

   dspm_active_set #(
      .N  (PATTERN_TOKENS),
      .CW (CW)
   ) u_active_set (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .hit_vec     (hit_vec),
      .star_vec    (star_vec),
      .token_count (token_count),
      .end_active  (end_active)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_matched_ff  <= end_active && !overflow;
         rsp_overflow_ff <= overflow;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_overflow_ff;

   a_no_match_on_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_overflow_ff |-> !rsp_matched_ff)
      else $error("verdict reports a match on an overflowed pattern");

   a_finish_gives_verdict: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("end-of-text word left no verdict");

   a_stall_only_on_blocked_verdict: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && rsp_valid_ff && !rsp_ready &&
                     (in_action_ff == ACT_FINISH))
      else $error("input stalled without a blocked verdict");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      token_count <= CW'(PATTERN_TOKENS))
      else $error("token count beyond the store");

endmodule
